### sv/gdr_pkg.sv
// ----------------------------------------------------------------------------
// gdr_pkg
// Types and constants shared by the grid DDA column raycaster modules.
// ----------------------------------------------------------------------------
package gdr_pkg;

  localparam int unsigned FRAC_BITS     = 16;
  localparam int unsigned SCREEN_HEIGHT = 480;
  localparam int unsigned MAP_SIZE      = 64;
  localparam int unsigned CELL_W        = 6;
  localparam int unsigned MAP_AW        = 2 * CELL_W;
  localparam int unsigned POS_W         = 22;
  localparam int unsigned VEC_W         = 18;

  localparam int unsigned QUOT_W = 2 * FRAC_BITS + 1;
  localparam int unsigned DEN_W  = 42;
  localparam int unsigned CNT_W  = 6;

  localparam logic [QUOT_W-1:0] ONE2        = QUOT_W'(1) << (2 * FRAC_BITS);
  localparam logic [QUOT_W-1:0] HEIGHT_NUM  = QUOT_W'(SCREEN_HEIGHT) << FRAC_BITS;
  localparam logic [9:0]        LH_MAX      = 10'(2 * SCREEN_HEIGHT);
  localparam logic [9:0]        HALF_H      = 10'(SCREEN_HEIGHT / 2);
  localparam logic [9:0]        LAST_ROW    = 10'(SCREEN_HEIGHT - 1);

  localparam logic [23:0] COLOR_XPOS = 24'hFF0000;
  localparam logic [23:0] COLOR_XNEG = 24'h00FF00;
  localparam logic [23:0] COLOR_YPOS = 24'h0000FF;
  localparam logic [23:0] COLOR_YNEG = 24'hFFFF00;

  localparam logic CMD_WRITE = 1'b0;

  localparam logic [2:0] REG_PLAYER_X = 3'd0;
  localparam logic [2:0] REG_PLAYER_Y = 3'd1;
  localparam logic [2:0] REG_DIR_X    = 3'd2;
  localparam logic [2:0] REG_DIR_Y    = 3'd3;
  localparam logic [2:0] REG_PLANE_X  = 3'd4;
  localparam logic [2:0] REG_PLANE_Y  = 3'd5;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

  typedef enum logic [20:0] {
    S_CLEAR = 21'd1 << 0,
    S_IDLE  = 21'd1 << 1,
    S_CAM   = 21'd1 << 2,
    S_MULX  = 21'd1 << 3,
    S_ADDX  = 21'd1 << 4,
    S_MULY  = 21'd1 << 5,
    S_ADDY  = 21'd1 << 6,
    S_DX    = 21'd1 << 7,
    S_DXW   = 21'd1 << 8,
    S_DY    = 21'd1 << 9,
    S_DYW   = 21'd1 << 10,
    S_SX1   = 21'd1 << 11,
    S_SX2   = 21'd1 << 12,
    S_SY1   = 21'd1 << 13,
    S_SY2   = 21'd1 << 14,
    S_STEP  = 21'd1 << 15,
    S_LOOK  = 21'd1 << 16,
    S_PERP  = 21'd1 << 17,
    S_DH    = 21'd1 << 18,
    S_DHW   = 21'd1 << 19,
    S_OUT   = 21'd1 << 20
  } state_e;

endpackage

### sv/gdr_div.sv
// ----------------------------------------------------------------------------
// gdr_div
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gdr_div
  import gdr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [QUOT_W-1:0] dividend_i,
  input  logic [DEN_W-1:0]  divisor_i,
  output logic              busy_o,
  output div_rsp_t          rsp_o
);

  logic              busy_q, done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [QUOT_W-1:0] num_q;
  logic [DEN_W-1:0]  rem_q, den_q;
  logic [DEN_W:0]    trial;
  logic              fits;

  assign trial = {rem_q, num_q[QUOT_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(QUOT_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
      num_q <= {num_q[QUOT_W-2:0], fits};
    end
  end

  assign busy_o     = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = num_q;

endmodule

### sv/grid_dda_column_raycaster.sv
// ----------------------------------------------------------------------------
// grid_dda_column_raycaster
// Casts one screen column ray through a 64x64 wall map by grid DDA.
// ----------------------------------------------------------------------------
// A cast that hits a wall uses the shared divider up to three times and does one
// map read per step; a ray that leaves the map skips the height division. One
// cast is in flight at a time, and the next transaction is taken in the same
// cycle that the result is first presented.
// After reset the map is cleared one cell a cycle, all 4096 cells, while no
// transaction is taken on the input stream; register writes work at once.
module grid_dda_column_raycaster
  import gdr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [23:0] s_tdata_i,  // column, cell_x, cell_y, wall_bit
  input  logic        s_tuser_i,  // cmd
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [55:0] m_tdata_o,  // span_start, span_end, wall_color, hit_side,
                                  // hit_x, hit_y, left_map
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [4:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);

  state_e state_q, state_d;

  logic [POS_W-1:0]        player_x_q, player_y_q;
  logic signed [VEC_W-1:0] dir_x_q, dir_y_q, plane_x_q, plane_y_q;

  logic              mem_q [MAP_SIZE*MAP_SIZE];
  logic              mem_we, mem_wdata, rd_q;
  logic [MAP_AW-1:0] mem_waddr, mem_raddr;
  logic [MAP_AW-1:0] clr_cnt_q;

  logic [9:0]         col_q;
  logic signed [19:0] cam_q;
  logic signed [37:0] prod_q;
  logic signed [37:0] prod_adj;
  logic signed [20:0] rx_q, ry_q;
  logic [QUOT_W-1:0]  dx_q, dy_q;
  logic [33:0]        acc_q;
  logic [DEN_W-1:0]   sx_q, sy_q, perp_q;
  logic [CELL_W-1:0]  mx_q, my_q;
  logic               side_q, left_q;
  logic [9:0]         lh_q;
  logic               m_valid_q;
  logic [55:0]        m_data_q;

  logic               accept, cfg_we;
  logic [27:0]        q5_prod;
  logic [19:0]        cam_sum;
  logic [16:0]        mul_a, mul_b;
  logic [33:0]        mul_p;
  logic [15:0]        fx, fy;
  logic               x_first, x_out, y_out;
  logic               div_start, div_busy;
  logic [QUOT_W-1:0]  div_num;
  logic [DEN_W-1:0]   div_den;
  div_rsp_t           div_rsp;
  logic [8:0]         h2;
  logic [9:0]         row_end;
  logic [23:0]        color;

  assign accept   = s_tvalid_i && s_tready_o;
  assign cfg_we   = psel_i && penable_i && pwrite_i;
  assign pready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      player_x_q <= 22'd2097152;
      player_y_q <= 22'd2097152;
      dir_x_q    <= -18'sd65536;
      dir_y_q    <= '0;
      plane_x_q  <= '0;
      plane_y_q  <= 18'sd43254;
    end else if (cfg_we) begin
      case (paddr_i[4:2])
        REG_PLAYER_X: player_x_q <= pwdata_i[POS_W-1:0];
        REG_PLAYER_Y: player_y_q <= pwdata_i[POS_W-1:0];
        REG_DIR_X:    dir_x_q    <= pwdata_i[VEC_W-1:0];
        REG_DIR_Y:    dir_y_q    <= pwdata_i[VEC_W-1:0];
        REG_PLANE_X:  plane_x_q  <= pwdata_i[VEC_W-1:0];
        REG_PLANE_Y:  plane_y_q  <= pwdata_i[VEC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr_i[4:2])
      REG_PLAYER_X: prdata_o = 32'(player_x_q);
      REG_PLAYER_Y: prdata_o = 32'(player_y_q);
      REG_DIR_X:    prdata_o = 32'(unsigned'(dir_x_q));
      REG_DIR_Y:    prdata_o = 32'(unsigned'(dir_y_q));
      REG_PLANE_X:  prdata_o = 32'(unsigned'(plane_x_q));
      REG_PLANE_Y:  prdata_o = 32'(unsigned'(plane_y_q));
      default:      prdata_o = '0;
    endcase
  end

  assign mem_we    = (state_q == S_CLEAR) ||
                     (accept && (s_tuser_i == CMD_WRITE));
  assign mem_waddr = (state_q == S_CLEAR) ? clr_cnt_q : {s_tdata_i[15:10], s_tdata_i[21:16]};
  assign mem_wdata = (state_q == S_CLEAR) ? 1'b0 : s_tdata_i[22];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem_q[mem_raddr];
  end

  assign fx = player_x_q[FRAC_BITS-1:0];
  assign fy = player_y_q[FRAC_BITS-1:0];

  assign q5_prod  = {col_q, 2'b00} * 16'hCCCD;
  assign cam_sum  = 20'(col_q) * 20'd204 + 20'(q5_prod[27:18]) - 20'd65536;
  assign prod_adj = prod_q + (prod_q[37] ? 38'sd65535 : 38'sd0);

  always_comb begin
    if (state_q == S_SX1 || state_q == S_SX2) begin
      mul_a = rx_q[20] ? {1'b0, fx} : 17'h10000 - {1'b0, fx};
      mul_b = (state_q == S_SX1) ? dx_q[32:16] : {1'b0, dx_q[15:0]};
    end else begin
      mul_a = ry_q[20] ? {1'b0, fy} : 17'h10000 - {1'b0, fy};
      mul_b = (state_q == S_SY1) ? dy_q[32:16] : {1'b0, dy_q[15:0]};
    end
  end
  assign mul_p = mul_a * mul_b;

  assign x_first   = sx_q < sy_q;
  assign x_out     = rx_q[20] ? (mx_q == '0) : (mx_q == CELL_W'(MAP_SIZE - 1));
  assign y_out     = ry_q[20] ? (my_q == '0) : (my_q == CELL_W'(MAP_SIZE - 1));
  assign mem_raddr = x_first ? {rx_q[20] ? mx_q - 1'b1 : mx_q + 1'b1, my_q}
                             : {mx_q, ry_q[20] ? my_q - 1'b1 : my_q + 1'b1};

  always_comb begin
    div_start = 1'b0;
    div_num   = ONE2;
    div_den   = '0;
    case (state_q)
      S_DX: begin
        div_start = (rx_q != '0);
        div_den   = DEN_W'(rx_q[20] ? -rx_q : rx_q);
      end
      S_DY: begin
        div_start = (ry_q != '0);
        div_den   = DEN_W'(ry_q[20] ? -ry_q : ry_q);
      end
      S_DH: begin
        div_start = (perp_q != '0);
        div_num   = HEIGHT_NUM;
        div_den   = perp_q;
      end
      default: ;
    endcase
  end

  gdr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .busy_o     (div_busy),
    .rsp_o      (div_rsp)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_cnt_q == '1) state_d = S_IDLE;
      S_IDLE:  if (accept && (s_tuser_i != CMD_WRITE)) state_d = S_CAM;
      S_CAM:   state_d = S_MULX;
      S_MULX:  state_d = S_ADDX;
      S_ADDX:  state_d = S_MULY;
      S_MULY:  state_d = S_ADDY;
      S_ADDY:  state_d = S_DX;
      S_DX:    state_d = div_start ? S_DXW : S_DY;
      S_DXW:   if (div_rsp.done) state_d = S_DY;
      S_DY:    state_d = div_start ? S_DYW : S_SX1;
      S_DYW:   if (div_rsp.done) state_d = S_SX1;
      S_SX1:   state_d = S_SX2;
      S_SX2:   state_d = S_SY1;
      S_SY1:   state_d = S_SY2;
      S_SY2:   state_d = S_STEP;
      S_STEP:  state_d = (x_first ? x_out : y_out) ? S_OUT : S_LOOK;
      S_LOOK:  state_d = rd_q ? S_PERP : S_STEP;
      S_PERP:  state_d = S_DH;
      S_DH:    state_d = div_start ? S_DHW : S_OUT;
      S_DHW:   if (div_rsp.done) state_d = S_OUT;
      S_OUT:   if (!m_valid_q || m_tready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_cnt_q <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (state_q == S_OUT && (!m_valid_q || m_tready_i)) begin
        m_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign h2      = lh_q[9:1];
  assign row_end = 10'(h2) + HALF_H;

  always_comb begin
    if (side_q) begin
      color = (!ry_q[20] && ry_q != '0) ? COLOR_YPOS : COLOR_YNEG;
    end else begin
      color = (!rx_q[20] && rx_q != '0) ? COLOR_XPOS : COLOR_XNEG;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        col_q  <= s_tdata_i[9:0];
        mx_q   <= player_x_q[POS_W-1:FRAC_BITS];
        my_q   <= player_y_q[POS_W-1:FRAC_BITS];
        left_q <= 1'b0;
        side_q <= 1'b0;
      end
      S_CAM:  cam_q  <= cam_sum;
      S_MULX: prod_q <= plane_x_q * cam_q;
      S_ADDX: rx_q   <= 21'(prod_adj[37:16]) + 21'(dir_x_q);
      S_MULY: prod_q <= plane_y_q * cam_q;
      S_ADDY: ry_q   <= 21'(prod_adj[37:16]) + 21'(dir_y_q);
      S_DX:   dx_q   <= ONE2;
      S_DXW:  if (div_rsp.done) dx_q <= div_rsp.quot;
      S_DY:   dy_q   <= ONE2;
      S_DYW:  if (div_rsp.done) dy_q <= div_rsp.quot;
      S_SX1, S_SY1: acc_q <= mul_p;
      S_SX2:  sx_q <= DEN_W'(acc_q) + DEN_W'(mul_p[33:16]);
      S_SY2:  sy_q <= DEN_W'(acc_q) + DEN_W'(mul_p[33:16]);
      S_STEP: begin
        if (x_first) begin
          side_q <= 1'b0;
          if (x_out) begin
            left_q <= 1'b1;
          end else begin
            sx_q <= sx_q + DEN_W'(dx_q);
            mx_q <= rx_q[20] ? mx_q - 1'b1 : mx_q + 1'b1;
          end
        end else begin
          side_q <= 1'b1;
          if (y_out) begin
            left_q <= 1'b1;
          end else begin
            sy_q <= sy_q + DEN_W'(dy_q);
            my_q <= ry_q[20] ? my_q - 1'b1 : my_q + 1'b1;
          end
        end
      end
      S_PERP: perp_q <= side_q ? sy_q - DEN_W'(dy_q) : sx_q - DEN_W'(dx_q);
      S_DH:   lh_q   <= LH_MAX;
      S_DHW: begin
        if (div_rsp.done) begin
          lh_q <= (div_rsp.quot > QUOT_W'(LH_MAX)) ? LH_MAX : div_rsp.quot[9:0];
        end
      end
      S_OUT: begin
        if (!m_valid_q || m_tready_i) begin
          if (left_q) begin
            m_data_q <= {1'b1, 55'd0};
          end else begin
            m_data_q <= {1'b0, my_q, mx_q, side_q, color,
                         row_end > LAST_ROW ? LAST_ROW[8:0] : row_end[8:0],
                         10'(h2) > HALF_H ? 9'd0 : 9'(HALF_H - 10'(h2))};
          end
        end
      end
      default: ;
    endcase
  end

  assign s_tready_o = (state_q == S_IDLE);
  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;

`ifndef SYNTHESIS
  a_no_input_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !s_tready_o) else $error("input taken during clear");
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy) else $error("divider restarted while busy");
  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == S_OUT)) else $error("stray result");
`endif

endmodule
